/* rtl/hsec_pkg.sv */
package hsec_pkg;

   localparam int MAX_CODE_BITS = 63;
   localparam int CODE_W        = 63;
   localparam int MSG_W         = 57;
   localparam int POS_W         = 6;
   localparam int PAR_MAX       = 6;
   localparam int PCNT_W        = 3;
   localparam int CSR_DATA_W    = 6;

   localparam logic [POS_W-1:0] MSG_LEN_RESET = POS_W'(4);
   localparam logic [POS_W-1:0] MSG_LEN_MAX   = POS_W'(MSG_W);

   // largest message length served by each parity count
   localparam logic [POS_W-1:0] MSG_LEN_P2 = POS_W'(1);
   localparam logic [POS_W-1:0] MSG_LEN_P3 = POS_W'(4);
   localparam logic [POS_W-1:0] MSG_LEN_P4 = POS_W'(11);
   localparam logic [POS_W-1:0] MSG_LEN_P5 = POS_W'(26);

   typedef enum logic {
      CMD_ENCODE = 1'b0,
      CMD_DECODE = 1'b1
   } cmd_type;

   typedef enum logic {
      CSR_MESSAGE_LENGTH = 1'b0,
      CSR_ODD_PARITY     = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [POS_W-1:0]  msg_len;
      logic [PCNT_W-1:0] par_cnt;
      logic [POS_W-1:0]  code_len;
      logic              odd;
   } cfg_type;

   function automatic bit is_pow2(input int pos);
      return (pos & (pos - 1)) == 0;
   endfunction

   // message bit carried at a non-power-of-two code position
   function automatic int msg_index(input int pos);
      return pos - $clog2(pos + 1) - 1;
   endfunction

   function automatic logic [CODE_W-1:0] cover_mask(input int k);
      logic [CODE_W-1:0] m;
      m = '0;
      for (int p = 1; p <= CODE_W; p++) begin
         if (((p >> k) & 1) == 1) begin
            m[p-1] = 1'b1;
         end
      end
      return m;
   endfunction

endpackage

/* rtl/hamming_sec_encode_decode.sv */
// An accepted request passes through the input register and the result register to rsp_tdata.
// Throughput: one request per cycle; the input and result registers both
// advance whenever the result register is empty or being taken.
// Reset: synchronous, active high; clears both stages and sets message
// length 4 with even parity.
module hamming_sec_encode_decode
   import hsec_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [119:0]          req_tdata,  // message_bits, code_word
   input  logic                  req_tuser,  // command
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [127:0]          rsp_tdata,  // code_out, message_out,
                                             // error_position, uncorrectable, zero
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type           cfg;
   logic              in_valid_ff, in_valid_in;
   logic              cmd_ff;
   logic [MSG_W-1:0]  msg_ff;
   logic [CODE_W-1:0] code_ff;
   logic              out_valid_ff, out_valid_in;
   logic [CODE_W-1:0] code_out_ff, code_out_in;
   logic [MSG_W-1:0]  msg_out_ff, msg_out_in;
   logic [POS_W-1:0]  err_pos_ff, err_pos_in;
   logic              uncor_ff, uncor_in;
   logic              out_en;
   logic              in_en;

   hsec_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   hsec_core u_core (
      .cfg            (cfg),
      .command        (cmd_ff),
      .message_bits   (msg_ff),
      .code_word      (code_ff),
      .code_out       (code_out_in),
      .message_out    (msg_out_in),
      .error_position (err_pos_in),
      .uncorrectable  (uncor_in)
   );

   assign out_en       = !out_valid_ff || rsp_tready;
   assign in_en        = !in_valid_ff || out_en;
   assign req_tready   = in_en;
   assign in_valid_in  = req_tvalid;
   assign out_valid_in = in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_en) begin
         in_valid_ff <= in_valid_in;
      end
   end

   // hold the request while the result stage is stalled
   always_ff @(posedge clock) begin
      if (in_en && req_tvalid) begin
         cmd_ff  <= req_tuser;
         msg_ff  <= req_tdata[MSG_W-1:0];
         code_ff <= req_tdata[MSG_W+CODE_W-1:MSG_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_en) begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && in_valid_ff) begin
         code_out_ff <= code_out_in;
         msg_out_ff  <= msg_out_in;
         err_pos_ff  <= err_pos_in;
         uncor_ff    <= uncor_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, uncor_ff, err_pos_ff, msg_out_ff, code_out_ff};

endmodule

/* rtl/hsec_csr.sv */
module hsec_csr
   import hsec_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   logic [POS_W-1:0]  msg_len_ff, msg_len_in;
   logic              odd_ff, odd_in;
   logic [POS_W-1:0]  n_eff;
   logic [PCNT_W-1:0] r_cnt;

   assign csr_ready = 1'b1;

   always_comb begin
      msg_len_in = msg_len_ff;
      odd_in     = odd_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_MESSAGE_LENGTH: msg_len_in = csr_data;
            CSR_ODD_PARITY:     odd_in     = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         msg_len_ff <= MSG_LEN_RESET;
         odd_ff     <= 1'b0;
      end else begin
         msg_len_ff <= msg_len_in;
         odd_ff     <= odd_in;
      end
   end

   // clamp length to 1..57, what fits the longest code word, and pick the parity count
   always_comb begin
      if (msg_len_ff == '0) begin
         n_eff = POS_W'(1);
      end else if (msg_len_ff > MSG_LEN_MAX) begin
         n_eff = MSG_LEN_MAX;
      end else begin
         n_eff = msg_len_ff;
      end
      if (n_eff <= MSG_LEN_P2) begin
         r_cnt = PCNT_W'(2);
      end else if (n_eff <= MSG_LEN_P3) begin
         r_cnt = PCNT_W'(3);
      end else if (n_eff <= MSG_LEN_P4) begin
         r_cnt = PCNT_W'(4);
      end else if (n_eff <= MSG_LEN_P5) begin
         r_cnt = PCNT_W'(5);
      end else begin
         r_cnt = PCNT_W'(6);
      end
   end

   assign cfg.msg_len  = n_eff;
   assign cfg.par_cnt  = r_cnt;
   assign cfg.code_len = n_eff + POS_W'(r_cnt);
   assign cfg.odd      = odd_ff;

endmodule

/* rtl/hsec_core.sv */
module hsec_core
   import hsec_pkg::*;
(
   input  cfg_type           cfg,
   input  logic              command,
   input  logic [MSG_W-1:0]  message_bits,
   input  logic [CODE_W-1:0] code_word,
   output logic [CODE_W-1:0] code_out,
   output logic [MSG_W-1:0]  message_out,
   output logic [POS_W-1:0]  error_position,
   output logic              uncorrectable
);

   logic [MSG_W-1:0]  msg_mask;
   logic [CODE_W-1:0] len_mask;
   logic [MSG_W-1:0]  msg_m;
   logic [CODE_W-1:0] spread;
   logic [CODE_W-1:0] rx_word;
   logic [CODE_W-1:0] base;
   logic [PAR_MAX-1:0] chk;
   logic [CODE_W-1:0] par_place;
   logic [CODE_W-1:0] flip;
   logic [CODE_W-1:0] fixed;
   logic [MSG_W-1:0]  msg_x;
   logic              decode;
   logic              beyond;

   assign decode   = (cmd_type'(command) == CMD_DECODE);
   assign msg_mask = ~({MSG_W{1'b1}} << cfg.msg_len);
   assign len_mask = ~({CODE_W{1'b1}} << cfg.code_len);
   assign msg_m    = message_bits & msg_mask;
   assign rx_word  = code_word & len_mask;
   assign base     = decode ? rx_word : spread;

   genvar gp, gk;
   generate
      for (gp = 1; gp <= CODE_W; gp++) begin : g_pos
         if (is_pow2(gp)) begin : g_par
            assign spread[gp-1] = 1'b0;
         end else begin : g_msg
            assign spread[gp-1]               = msg_m[msg_index(gp)];
            assign msg_x[msg_index(gp)]       = fixed[gp-1];
         end
         assign flip[gp-1] = (error_position == POS_W'(gp)) && !beyond;
      end

      // one check group per parity bit; shared by encode and decode
      for (gk = 0; gk < PAR_MAX; gk++) begin : g_chk
         localparam logic [CODE_W-1:0] CoverMask = cover_mask(gk);
         assign chk[gk] = (PCNT_W'(gk) < cfg.par_cnt) && (cfg.odd ^ (^(base & CoverMask)));
      end
   endgenerate

   always_comb begin
      par_place = '0;
      for (int k = 0; k < PAR_MAX; k++) begin
         par_place[(1 << k) - 1] = chk[k];
      end
   end

   assign error_position = decode ? chk : '0;
   assign beyond         = (error_position != '0) && (error_position > cfg.code_len);
   assign uncorrectable  = beyond;
   assign fixed          = rx_word ^ flip;
   assign code_out       = decode ? fixed : (spread | par_place);
   assign message_out    = decode ? msg_x : msg_m;

endmodule
